### hw/rtl/smb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smb_pkg;

  // field widths
  localparam int ModeW    = 3;
  localparam int AddrW    = 16;
  localparam int DataW    = 8;
  localparam int OffsetW  = 19;
  localparam int MirrorW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;
  localparam int BankW    = 5;
  localparam int SizeW    = 6;

  // remainder unit: one restoring step per cycle, quotient below 32
  localparam int DivSteps  = 5;
  localparam int StepCntW  = 3;
  localparam int RemW      = 24;

  // bus operation codes
  localparam logic [ModeW-1:0] ModeWrite        = 3'd0;
  localparam logic [ModeW-1:0] ModePrgRead      = 3'd1;
  localparam logic [ModeW-1:0] ModeRamAccess    = 3'd2;
  localparam logic [ModeW-1:0] ModePattern      = 3'd3;
  localparam logic [ModeW-1:0] ModeConsoleReset = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgVariantB  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFixed32k  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPrgBanks  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgChrBanks  = 2'd3;

  // serial load targets, from address bits 14..13
  localparam logic [1:0] RegControl = 2'd0;
  localparam logic [1:0] RegChrLow  = 2'd1;
  localparam logic [1:0] RegChrHigh = 2'd2;
  localparam logic [1:0] RegPrgBank = 2'd3;

  // prg modes from control bits 3..2
  localparam logic [1:0] PrgModeFixFirst = 2'd2;
  localparam logic [1:0] PrgModeFixLast  = 2'd3;

  localparam logic [BankW-1:0] ShifterReset = 5'h10;
  localparam logic [BankW-1:0] ControlReset = 5'h0C;
  localparam logic [BankW-1:0] PrgModeForce = 5'h0C;
  localparam logic [BankW-1:0] RamEnMask    = 5'h0F;
  localparam logic [AddrW-1:0] RamBase      = 16'h6000;
  localparam logic [SizeW-1:0] ChrMaxUnits  = 6'd32;
  localparam logic [SizeW-1:0] SizeMin      = 6'd1;

  localparam int PrgBankShift = 14;
  localparam int ChrUnitShift = 12;

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StDivide,
    StEmit
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/smb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smb_in_if import smb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] data;

  modport source (output valid, mode, address, data, input ready);
  modport sink (input valid, mode, address, data, output ready);
endinterface

interface smb_out_if import smb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OffsetW-1:0] offset;
  logic               ram_enabled;
  logic [MirrorW-1:0] mirroring;
  logic               register_loaded;

  modport source (output valid, offset, ram_enabled, mirroring, register_loaded, input ready);
  modport sink (input valid, offset, ram_enabled, mirroring, register_loaded, output ready);
endinterface

`default_nettype wire

### hw/rtl/smb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module smb_ctrl import smb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  localparam logic [StepCntW-1:0] LastStep = StepCntW'(DivSteps - 1);

  ctl_state_e          state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        state_d = StDivide;
        cnt_d   = '0;
      end
      StDivide: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!status_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
      end
      StDivide: begin
        cmd_o.step = 1'b1;
      end
      StEmit: begin
        cmd_o.emit = !status_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/smb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module smb_datapath import smb_pkg::*; #(
  parameter int MAX_PRG_BANKS = 32,
  parameter int PRG_RAM_BYTES = 8192
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_status_t               status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [ModeW-1:0]    mode_i,
  input  wire logic [AddrW-1:0]    address_i,
  input  wire logic [DataW-1:0]    data_i,
  smb_out_if.source                out_o
);

  localparam logic [SizeW-1:0] MaxPrgBanks = SizeW'(MAX_PRG_BANKS);
  localparam logic [RemW-1:0]  RamDiv      = RemW'(PRG_RAM_BYTES) << (DivSteps - 1);

  // captured item
  logic [ModeW-1:0] mode_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] data_q;

  // configuration
  logic             variant_b_q, fixed32_q;
  logic [SizeW-1:0] prg_banks_q, chr_banks_q;

  // mapper state
  logic [BankW-1:0] shifter_q, shifter_d;
  logic [BankW-1:0] control_q, control_d;
  logic [BankW-1:0] chr_lo_q, chr_lo_d;
  logic [BankW-1:0] chr_hi_q, chr_hi_d;
  logic [BankW-1:0] prg_q, prg_d;
  logic             loaded_q, loaded_d;

  // remainder unit
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] div_q, div_d;
  logic [RemW-1:0] prep_rem, prep_div;

  // result register
  logic               out_valid_q;
  logic [OffsetW-1:0] out_offset_q;
  logic               out_ram_q;
  logic [MirrorW-1:0] out_mirror_q;
  logic               out_loaded_q;

  logic [SizeW-1:0] prg_banks, chr_units;
  logic [BankW-1:0] last_bank, prg_bank_sel;
  logic [1:0]       pmode;
  logic             upper, fixed_half, ram_on;
  logic [BankW-1:0] shift_in;
  logic [AddrW-1:0] ram_off;

  assign ram_on   = !(variant_b_q && prg_q[BankW-1]);
  assign shift_in = {data_q[0], shifter_q[BankW-1:1]};
  assign ram_off  = addr_q - RamBase;

  // size clamps
  always_comb begin
    if (prg_banks_q == '0) begin
      prg_banks = SizeMin;
    end else if (prg_banks_q > MaxPrgBanks) begin
      prg_banks = MaxPrgBanks;
    end else begin
      prg_banks = prg_banks_q;
    end
    if (chr_banks_q == '0) begin
      chr_units = SizeMin;
    end else if (chr_banks_q > ChrMaxUnits) begin
      chr_units = ChrMaxUnits;
    end else begin
      chr_units = chr_banks_q;
    end
  end

  // prg window bank select
  always_comb begin
    pmode      = control_q[3:2];
    upper      = addr_q[PrgBankShift];
    fixed_half = (pmode == PrgModeFixLast) ? upper : !upper;
    last_bank  = BankW'(prg_banks - SizeMin);
    if (fixed_half) begin
      prg_bank_sel = upper ? last_bank : '0;
    end else begin
      prg_bank_sel = {1'b0, prg_q[3:0]};
    end
  end

  // dividend and pre-shifted divisor per operation
  always_comb begin
    prep_rem = '0;
    prep_div = RamDiv;
    case (mode_q)
      ModePrgRead: begin
        prep_div = RemW'(prg_banks) << (PrgBankShift + DivSteps - 1);
        if (pmode != PrgModeFixFirst && pmode != PrgModeFixLast) begin
          prep_rem = RemW'({prg_q[3:1], addr_q[14:0]});
        end else if (fixed32_q) begin
          prep_rem = RemW'(addr_q[14:0]);
        end else begin
          prep_rem = RemW'({prg_bank_sel, addr_q[13:0]});
        end
      end
      ModeRamAccess: begin
        if (ram_on) begin
          prep_rem = RemW'(ram_off);
        end
      end
      ModePattern: begin
        prep_div = RemW'(chr_units) << (ChrUnitShift + DivSteps - 1);
        if (!control_q[4]) begin
          prep_rem = RemW'({chr_lo_q[4:1], addr_q[12:0]});
        end else if (addr_q[12]) begin
          prep_rem = RemW'({chr_hi_q, addr_q[11:0]});
        end else begin
          prep_rem = RemW'({chr_lo_q, addr_q[11:0]});
        end
      end
      default: begin
        prep_rem = '0;
      end
    endcase
  end

  // serial port and console reset
  always_comb begin
    shifter_d = shifter_q;
    control_d = control_q;
    chr_lo_d  = chr_lo_q;
    chr_hi_d  = chr_hi_q;
    prg_d     = prg_q;
    loaded_d  = loaded_q;
    if (cmd_i.prep) begin
      loaded_d = 1'b0;
      case (mode_q)
        ModeWrite: begin
          if (addr_q[AddrW-1]) begin
            if (data_q[DataW-1]) begin
              shifter_d = ShifterReset;
              control_d = control_q | PrgModeForce;
            end else if (shifter_q[0]) begin
              shifter_d = ShifterReset;
              loaded_d  = 1'b1;
              case (addr_q[14:13])
                RegControl: control_d = shift_in;
                RegChrLow:  chr_lo_d  = shift_in;
                RegChrHigh: chr_hi_d  = shift_in;
                RegPrgBank: prg_d     = shift_in;
                default:    prg_d     = shift_in;
              endcase
            end else begin
              shifter_d = shift_in;
            end
          end
        end
        ModeConsoleReset: begin
          shifter_d = ShifterReset;
          control_d = ControlReset;
          chr_lo_d  = '0;
          chr_hi_d  = '0;
          prg_d     = variant_b_q ? (prg_q & RamEnMask) : '0;
        end
        default: begin
          shifter_d = shifter_q;
        end
      endcase
    end
  end

  // restoring remainder, one quotient bit per step
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    if (cmd_i.prep) begin
      rem_d = prep_rem;
      div_d = prep_div;
    end else if (cmd_i.step) begin
      if (rem_q >= div_q) begin
        rem_d = rem_q - div_q;
      end
      div_d = div_q >> 1;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      addr_q <= address_i;
      data_q <= data_i;
    end
    rem_q    <= rem_d;
    div_q    <= div_d;
    loaded_q <= loaded_d;
    if (cmd_i.emit) begin
      out_offset_q <= rem_q[OffsetW-1:0];
      out_ram_q    <= ram_on;
      out_mirror_q <= control_q[MirrorW-1:0];
      out_loaded_q <= loaded_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_b_q <= 1'b1;
      fixed32_q   <= 1'b0;
      prg_banks_q <= 6'd2;
      chr_banks_q <= 6'd2;
      shifter_q   <= ShifterReset;
      control_q   <= ControlReset;
      chr_lo_q    <= '0;
      chr_hi_q    <= '0;
      prg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgVariantB: variant_b_q <= cfg_data_i[0];
          CfgFixed32k: fixed32_q   <= cfg_data_i[0];
          CfgPrgBanks: prg_banks_q <= cfg_data_i;
          CfgChrBanks: chr_banks_q <= cfg_data_i;
          default:     chr_banks_q <= cfg_data_i;
        endcase
      end
      shifter_q <= shifter_d;
      control_q <= control_d;
      chr_lo_q  <= chr_lo_d;
      chr_hi_q  <= chr_hi_d;
      prg_q     <= prg_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.offset          = out_offset_q;
  assign out_o.ram_enabled     = out_ram_q;
  assign out_o.mirroring       = out_mirror_q;
  assign out_o.register_loaded = out_loaded_q;

endmodule

`default_nettype wire

### hw/rtl/serial_loaded_bank_mapper.sv
// an accepted item is captured, prepared, run through five remainder steps, then emitted to out_o
// items are taken one at a time: in_i.ready is high only while idle, so the five-step shared remainder unit
// finishes one item (capture, prepare, five remainder steps, emit) before the next is accepted
// a finished result waits in the output register while the next item is accepted
// reset: async active low; config regs, bank regs and control clear to reset values
`timescale 1ns / 1ps
`default_nettype none

module serial_loaded_bank_mapper import smb_pkg::*; #(
  parameter int MAX_PRG_BANKS = 32,
  parameter int PRG_RAM_BYTES = 8192
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  smb_in_if.sink                   in_i,
  smb_out_if.source                out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // sequencer: idle, prepare, remainder steps, emit
  smb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // bank registers, address translation and the output register
  smb_datapath #(
    .MAX_PRG_BANKS (MAX_PRG_BANKS),
    .PRG_RAM_BYTES (PRG_RAM_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (in_i.mode),
    .address_i   (in_i.address),
    .data_i      (in_i.data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
